// File: src/aced_pkg.sv
// shared types and codes for the ansi-c escape decoder
// used by aced_decode and ansi_c_escape_decoder; depends on nothing
`default_nettype none

package aced_pkg;

  // most results one input beat can cause
  localparam int unsigned MAX_RES = 5;
  localparam int unsigned RES_IDX_W = 3;

  // decoder state codes
  localparam logic [2:0] MODE_PLAIN     = 3'd0;
  localparam logic [2:0] MODE_BACKSLASH = 3'd1;
  localparam logic [2:0] MODE_HEX       = 3'd2;
  localparam logic [2:0] MODE_OCTAL     = 3'd3;
  localparam logic [2:0] MODE_DROP      = 3'd4;

  // hex escape flavors
  localparam logic [1:0] KIND_X     = 2'd0;
  localparam logic [1:0] KIND_U     = 2'd1;
  localparam logic [1:0] KIND_BIG_U = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NEED_DIGITS = 2'd0;
  localparam logic [1:0] ERR_RANGE       = 2'd1;
  localparam logic [1:0] ERR_TRAILING    = 2'd2;

  localparam logic [31:0] CODE_LIMIT = 32'h0010_FFFF;
  localparam logic [7:0]  ESC_BYTE   = 8'h1B;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       err;
    logic [1:0] kind;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  // everything one input beat produces
  typedef struct packed {
    res_list_t            list;
    logic [RES_IDX_W-1:0] count;
    logic                 eot;
  } dec_t;

endpackage

`default_nettype wire

// File: src/aced_decode.sv
// escape decoding state and the single-pass decode of one input beat
// depends on aced_pkg
`default_nettype none

module aced_decode (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          beat_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          eot_i,
  output aced_pkg::dec_t     dec_o
);
  import aced_pkg::*;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_LA        = 8'h61;
  localparam logic [7:0] CH_LB        = 8'h62;
  localparam logic [7:0] CH_LE        = 8'h65;
  localparam logic [7:0] CH_UE        = 8'h45;
  localparam logic [7:0] CH_LF        = 8'h66;
  localparam logic [7:0] CH_LN        = 8'h6E;
  localparam logic [7:0] CH_LR        = 8'h72;
  localparam logic [7:0] CH_LT        = 8'h74;
  localparam logic [7:0] CH_LV        = 8'h76;
  localparam logic [7:0] CH_LX        = 8'h78;
  localparam logic [7:0] CH_LU        = 8'h75;
  localparam logic [7:0] CH_UU        = 8'h55;

  typedef struct packed {
    logic            err;
    logic [1:0]      kind;
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } fin_t;

  function automatic fin_t utf8_enc(input logic [20:0] cp);
    fin_t f;
    f = '0;
    if (cp < 21'h80) begin
      f.n = 3'd1;
      f.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      f.n = 3'd2;
      f.b[0] = {3'b110, cp[10:6]};
      f.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      f.n = 3'd3;
      f.b[0] = {4'b1110, cp[15:12]};
      f.b[1] = {2'b10, cp[11:6]};
      f.b[2] = {2'b10, cp[5:0]};
    end else begin
      f.n = 3'd4;
      f.b[0] = {5'b11110, cp[20:18]};
      f.b[1] = {2'b10, cp[17:12]};
      f.b[2] = {2'b10, cp[11:6]};
      f.b[3] = {2'b10, cp[5:0]};
    end
    return f;
  endfunction

  // closes a pending hex or octal escape
  function automatic fin_t finish(input logic [2:0] m, input logic [1:0] k,
                                  input logic [3:0] c, input logic [31:0] a);
    fin_t f;
    f = '0;
    if (m == MODE_HEX) begin
      if (c == 4'd0) begin
        f.err  = 1'b1;
        f.kind = ERR_NEED_DIGITS;
      end else if (k == KIND_X) begin
        f.n    = 3'd1;
        f.b[0] = a[7:0];
      end else if (a > CODE_LIMIT) begin
        f.err  = 1'b1;
        f.kind = ERR_RANGE;
      end else begin
        f = utf8_enc(a[20:0]);
      end
    end else begin
      f = utf8_enc({12'd0, a[8:0]});
    end
    return f;
  endfunction

  logic [2:0]  mode_q, mode_d;
  logic [1:0]  kind_q, kind_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;

  logic            is_hex, is_oct, take, early_fin, dig_src, late_fin, run_plain;
  logic            trail_err;
  logic [3:0]      hex_val, limit, cnt_inc;
  logic [31:0]     hex_acc, oct_acc;
  logic [2:0]      mode_p;
  logic [1:0]      kind_p;
  logic [3:0]      cnt_p;
  logic [31:0]     acc_p;
  logic [1:0]      bs_n;
  logic [1:0][7:0] bs_b;
  logic [2:0]      fin_mode;
  logic [1:0]      fin_kind;
  logic [3:0]      fin_cnt;
  logic [31:0]     fin_acc;
  fin_t            fin;
  res_list_t       list;
  logic [RES_IDX_W-1:0] n;
  res_t            ent;

  always_comb begin
    // digit classification
    is_hex  = 1'b0;
    hex_val = byte_i[3:0];
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      is_hex = 1'b1;
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      is_hex  = 1'b1;
      hex_val = byte_i[3:0] + 4'd9;
    end
    is_oct  = (byte_i[7:3] == 5'b00110);
    limit   = (kind_q == KIND_X) ? 4'd2 : ((kind_q == KIND_U) ? 4'd4 : 4'd8);
    cnt_inc = cnt_q + 4'd1;
    hex_acc = {acc_q[27:0], hex_val};
    oct_acc = {23'd0, acc_q[5:0], byte_i[2:0]};

    take      = 1'b0;
    early_fin = 1'b0;
    dig_src   = 1'b0;
    run_plain = 1'b0;
    mode_p    = mode_q;
    kind_p    = kind_q;
    cnt_p     = cnt_q;
    acc_p     = acc_q;
    bs_n      = 2'd0;
    bs_b      = '0;

    unique case (mode_q)
      MODE_HEX: begin
        if (is_hex && cnt_q < limit) begin
          take = 1'b1;
          if (cnt_inc >= limit) begin
            early_fin = 1'b1;
            dig_src   = 1'b1;
          end else begin
            cnt_p = cnt_inc;
            acc_p = hex_acc;
          end
        end else begin
          early_fin = 1'b1;
        end
      end
      MODE_OCTAL: begin
        if (is_oct && cnt_q < 4'd3) begin
          take = 1'b1;
          if (cnt_inc >= 4'd3) begin
            early_fin = 1'b1;
            dig_src   = 1'b1;
          end else begin
            cnt_p = cnt_inc;
            acc_p = oct_acc;
          end
        end else begin
          early_fin = 1'b1;
        end
      end
      MODE_BACKSLASH: begin
        mode_p = MODE_PLAIN;
        kind_p = KIND_X;
        cnt_p  = 4'd0;
        acc_p  = 32'd0;
        bs_n   = 2'd1;
        unique case (byte_i)
          CH_BACKSLASH: bs_b[0] = CH_BACKSLASH;
          CH_LA:        bs_b[0] = 8'h07;
          CH_LB:        bs_b[0] = 8'h08;
          CH_LE, CH_UE: bs_b[0] = ESC_BYTE;
          CH_LF:        bs_b[0] = 8'h0C;
          CH_LN:        bs_b[0] = 8'h0A;
          CH_LR:        bs_b[0] = 8'h0D;
          CH_LT:        bs_b[0] = 8'h09;
          CH_LV:        bs_b[0] = 8'h0B;
          CH_QUOTE:     bs_b[0] = CH_QUOTE;
          CH_LX: begin
            bs_n   = 2'd0;
            mode_p = MODE_HEX;
          end
          CH_LU: begin
            bs_n   = 2'd0;
            mode_p = MODE_HEX;
            kind_p = KIND_U;
          end
          CH_UU: begin
            bs_n   = 2'd0;
            mode_p = MODE_HEX;
            kind_p = KIND_BIG_U;
          end
          default: begin
            if (is_oct) begin
              bs_n   = 2'd0;
              mode_p = MODE_OCTAL;
              cnt_p  = 4'd1;
              acc_p  = {29'd0, byte_i[2:0]};
            end else begin
              // unknown escape goes out literally
              bs_n    = 2'd2;
              bs_b[0] = CH_BACKSLASH;
              bs_b[1] = byte_i;
            end
          end
        endcase
      end
      MODE_PLAIN: run_plain = 1'b1;
      default: ;
    endcase

    // one close per beat at most: before the byte, or at end of text
    late_fin = !early_fin && eot_i && (mode_p == MODE_HEX || mode_p == MODE_OCTAL);
    if (early_fin) begin
      fin_mode = mode_q;
      fin_kind = kind_q;
      fin_cnt  = dig_src ? cnt_inc : cnt_q;
      fin_acc  = dig_src ? ((mode_q == MODE_HEX) ? hex_acc : oct_acc) : acc_q;
    end else begin
      fin_mode = mode_p;
      fin_kind = kind_p;
      fin_cnt  = cnt_p;
      fin_acc  = acc_p;
    end
    fin = finish(fin_mode, fin_kind, fin_cnt, fin_acc);

    if (early_fin) begin
      kind_p = KIND_X;
      cnt_p  = 4'd0;
      acc_p  = 32'd0;
      if (fin.err) begin
        mode_p = MODE_DROP;
      end else begin
        mode_p    = MODE_PLAIN;
        run_plain = !take;
      end
    end

    if (run_plain) begin
      if (byte_i == CH_BACKSLASH) begin
        mode_p = MODE_BACKSLASH;
      end else begin
        bs_n    = 2'd1;
        bs_b[0] = byte_i;
      end
    end

    trail_err = eot_i && (mode_p == MODE_BACKSLASH);

    // next state
    if (eot_i) begin
      mode_d = MODE_PLAIN;
      kind_d = KIND_X;
      cnt_d  = 4'd0;
      acc_d  = 32'd0;
    end else begin
      mode_d = mode_p;
      kind_d = kind_p;
      cnt_d  = cnt_p;
      acc_d  = acc_p;
    end

    // pack results in emission order
    list = '0;
    n    = '0;
    ent  = '0;
    if (early_fin) begin
      if (fin.err) begin
        ent = '{data: 8'd0, valid: 1'b0, err: 1'b1, kind: fin.kind};
        list[n] = ent;
        n = n + 3'd1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < fin.n) begin
            ent = '{data: fin.b[i], valid: 1'b1, err: 1'b0, kind: 2'd0};
            list[n] = ent;
            n = n + 3'd1;
          end
        end
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (2'(i) < bs_n) begin
        ent = '{data: bs_b[i], valid: 1'b1, err: 1'b0, kind: 2'd0};
        list[n] = ent;
        n = n + 3'd1;
      end
    end
    if (late_fin) begin
      if (fin.err) begin
        ent = '{data: 8'd0, valid: 1'b0, err: 1'b1, kind: fin.kind};
        list[n] = ent;
        n = n + 3'd1;
      end else begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < fin.n) begin
            ent = '{data: fin.b[i], valid: 1'b1, err: 1'b0, kind: 2'd0};
            list[n] = ent;
            n = n + 3'd1;
          end
        end
      end
    end
    if (trail_err) begin
      ent = '{data: 8'd0, valid: 1'b0, err: 1'b1, kind: ERR_TRAILING};
      list[n] = ent;
      n = n + 3'd1;
    end
    if (eot_i && n == 3'd0) begin
      // empty close-out beat for a string with nothing left to say
      ent = '0;
      list[n] = ent;
      n = n + 3'd1;
    end
  end

  assign dec_o.list  = list;
  assign dec_o.count = n;
  assign dec_o.eot   = eot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      kind_q <= KIND_X;
      cnt_q  <= 4'd0;
      acc_q  <= 32'd0;
    end else if (beat_i) begin
      mode_q <= mode_d;
      kind_q <= kind_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

// File: src/ansi_c_escape_decoder.sv
// Decoder for the body of a shell $'...' string. Each input beat carries one
// raw body byte with tlast on the final byte; each output beat carries one
// decoded byte, an error report, or an empty close-out. The escape state is
// decoded in a single pass as the beat is accepted and all results it causes
// are loaded into an output register bank, which drains one beat per cycle
// while m_axis_tready is high. A byte that yields one result flows at one
// beat per cycle while the output is not stalled; a byte that yields n results
// (up to 5, for a finished UTF-8 sequence followed by the byte that ended it)
// holds the input until the bank has drained its last result. The first result
// shows in the cycle after the input beat. After a malformed escape the rest of
// the string up to tlast is dropped. No clearing pass after reset.
// depends on aced_pkg and aced_decode
`default_nettype none

module ansi_c_escape_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // end_of_text
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [7:0]      m_axis_tuser,   // [0] byte_valid, [1] error_flag,
                                          // [3:2] error_kind, [4] run_last, [7:5] zero
  output logic            m_axis_tlast    // text_done
);
  import aced_pkg::*;

  dec_t                 dec;
  res_list_t            list_q;
  logic [RES_IDX_W-1:0] n_q, rd_q;
  logic                 eot_q, valid_q;
  logic                 accept, last;
  res_t                 cur;

  assign last          = (rd_q == n_q - 3'd1);
  assign s_axis_tready = !valid_q || (m_axis_tready && last);
  assign accept        = s_axis_tvalid && s_axis_tready;

  aced_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (accept),
    .byte_i (s_axis_tdata),
    .eot_i  (s_axis_tlast),
    .dec_o  (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      n_q     <= '0;
      rd_q    <= '0;
      eot_q   <= 1'b0;
    end else if (accept) begin
      valid_q <= (dec.count != 3'd0);
      n_q     <= dec.count;
      rd_q    <= '0;
      eot_q   <= dec.eot;
    end else if (valid_q && m_axis_tready) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        rd_q <= rd_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      list_q <= dec.list;
    end
  end

  assign cur           = list_q[rd_q];
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = cur.data;
  assign m_axis_tuser  = {3'd0, last, cur.kind, cur.err, cur.valid};
  assign m_axis_tlast  = last && eot_q;

`ifndef NO_ASSERTIONS
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rd_q < n_q))
    else $error("read pointer beyond loaded results");

  a_load_starts_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && dec.count != 3'd0) |=> (valid_q && rd_q == 3'd0))
    else $error("loaded results not shown from the first entry");

  a_eot_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |-> (dec.count != 3'd0))
    else $error("end of text produced no result");

  a_err_not_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cur.err) |-> (!cur.valid && cur.data == 8'd0))
    else $error("error beat also carries a byte");

  a_done_only_on_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !cur.valid && !cur.err) |-> (last && eot_q))
    else $error("empty beat outside end of text");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// testbench for ansi_c_escape_decoder: directed table, then random $'...' bodies
// predicts every decoded beat in place and checks the output stream field by field
// depends on aced_pkg and the decoder rtl
module tb_top;
  import aced_pkg::*;

  localparam int unsigned RAND_ITEMS  = 450;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       err;
    logic [1:0] kind;
    logic       run_last;
    logic       done;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
    logic       fixed;
    out_beat_t  want;
  } dir_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [7:0] m_axis_tuser;
  logic       m_axis_tlast;

  // decoder state as predicted
  logic [2:0]  st_mode;
  logic [1:0]  st_kind;
  logic [3:0]  st_digits;
  logic [31:0] st_code;

  out_beat_t   step_res[$];
  out_beat_t   decoded_q[$];
  dir_row_t    dir_tab[$];
  logic [7:0]  str_bytes[$];
  out_beat_t   head;

  int unsigned err_cnt = 0;
  int unsigned out_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        quiet = 1'b0;
  logic        long_hold = 1'b0;

  ansi_c_escape_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** ansi_c_escape_decoder: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit(logic [7:0] d, logic v, logic e, logic [1:0] k);
    out_beat_t r;
    r = '{data: d, valid: v, err: e, kind: k, run_last: 1'b0, done: 1'b0};
    if (step_res.size() < MAX_RES) step_res.push_back(r);
  endfunction

  function automatic void emit_byte(logic [7:0] d);
    emit(d, 1'b1, 1'b0, '0);
  endfunction

  function automatic void raise_error(logic [1:0] k);
    emit(8'h00, 1'b0, 1'b1, k);
    st_mode = MODE_DROP;
    st_digits = '0;
    st_code = '0;
  endfunction

  function automatic void to_plain();
    st_mode = MODE_PLAIN;
    st_kind = KIND_X;
    st_digits = '0;
    st_code = '0;
  endfunction

  function automatic void emit_utf8(logic [31:0] cp);
    if (cp < 32'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int digit_limit();
    return (st_kind == KIND_X) ? 2 : ((st_kind == KIND_U) ? 4 : 8);
  endfunction

  function automatic void finish_escape();
    if (st_mode == MODE_HEX) begin
      if (st_digits == 0) begin
        raise_error(ERR_NEED_DIGITS);
        return;
      end
      if (st_kind == KIND_X) begin
        emit_byte(st_code[7:0]);
      end else if (st_code > CODE_LIMIT) begin
        raise_error(ERR_RANGE);
        return;
      end else begin
        emit_utf8(st_code);
      end
    end else if (st_mode == MODE_OCTAL) begin
      emit_utf8({23'd0, st_code[8:0]});
    end
    to_plain();
  endfunction

  function automatic void after_backslash(logic [7:0] b);
    to_plain();
    case (b)
      "\\": emit_byte("\\");
      "a": emit_byte(8'h07);
      "b": emit_byte(8'h08);
      "e", "E": emit_byte(ESC_BYTE);
      "f": emit_byte(8'h0C);
      "n": emit_byte(8'h0A);
      "r": emit_byte(8'h0D);
      "t": emit_byte(8'h09);
      "v": emit_byte(8'h0B);
      "'": emit_byte("'");
      "x", "u", "U": begin
        st_mode = MODE_HEX;
        st_kind = (b == "x") ? KIND_X : ((b == "u") ? KIND_U : KIND_BIG_U);
      end
      default: begin
        if (b >= "0" && b <= "7") begin
          st_mode = MODE_OCTAL;
          st_digits = 4'd1;
          st_code = {29'd0, b[2:0]};
        end else begin
          // unknown escape goes through with its backslash
          emit_byte("\\");
          emit_byte(b);
        end
      end
    endcase
  endfunction

  function automatic void unescape_step(logic [7:0] b, logic eot);
    logic      taken;
    int        v;
    out_beat_t r;
    step_res.delete();
    taken = 1'b0;
    case (st_mode)
      MODE_HEX: begin
        v = hex_digit(b);
        if (v >= 0 && st_digits < digit_limit()) begin
          st_code = {st_code[27:0], v[3:0]};
          st_digits++;
          taken = 1'b1;
          if (st_digits >= digit_limit()) finish_escape();
        end else begin
          finish_escape();
        end
      end
      MODE_OCTAL: begin
        if (b >= "0" && b <= "7" && st_digits < 3) begin
          st_code = {23'd0, st_code[5:0], b[2:0]};
          st_digits++;
          taken = 1'b1;
          if (st_digits >= 3) finish_escape();
        end else begin
          finish_escape();
        end
      end
      MODE_BACKSLASH: begin
        after_backslash(b);
        taken = 1'b1;
      end
      MODE_PLAIN: ;
      default: taken = 1'b1;
    endcase
    // a byte that ended an escape is decoded afresh here
    if (!taken && st_mode == MODE_PLAIN) begin
      if (b == "\\") st_mode = MODE_BACKSLASH;
      else emit_byte(b);
    end
    if (eot) begin
      if (st_mode == MODE_BACKSLASH) raise_error(ERR_TRAILING);
      else if (st_mode == MODE_HEX || st_mode == MODE_OCTAL) finish_escape();
      to_plain();
      if (step_res.size() == 0) emit(8'h00, 1'b0, 1'b0, '0);
      r = step_res.pop_back();
      r.done = 1'b1;
      step_res.push_back(r);
    end
    if (step_res.size() > 0) begin
      r = step_res.pop_back();
      r.run_last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic dir_row_t step_only(logic [7:0] b, logic l);
    dir_row_t r;
    r = '0;
    r.in_byte = b;
    r.last = l;
    return r;
  endfunction

  function automatic dir_row_t step_fixed(logic [7:0] b, logic l, logic [7:0] d,
                                          logic v, logic e, logic [1:0] k);
    dir_row_t r;
    r.in_byte = b;
    r.last = l;
    r.fixed = 1'b1;
    r.want = '{data: d, valid: v, err: e, kind: k, run_last: 1'b1, done: l};
    return r;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l, input logic fixed,
                           input out_beat_t want);
    s_axis_tdata <= b;
    s_axis_tlast <= l;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    unescape_step(b, l);
    if (fixed) decoded_q.push_back(want);
    else foreach (step_res[i]) decoded_q.push_back(step_res[i]);
    @(negedge clk_i);
  endtask

  task automatic maybe_idle();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain_out();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (decoded_q.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
  endfunction

  // cp written as nd hex digits, most significant first
  function automatic void add_hex(logic [31:0] cp, int nd);
    logic [31:0] sh;
    for (int i = nd - 1; i >= 0; i--) begin
      sh = cp >> (4 * i);
      str_bytes.push_back(hex_char(sh[3:0]));
    end
  endfunction

  function automatic int hex_width(logic [31:0] cp);
    int w;
    w = 1;
    while (w < 8 && (cp >> (4 * w)) != 0) w++;
    return w;
  endfunction

  function automatic void add_hex_escape(logic [7:0] letter, logic [31:0] cp, int max_nd);
    str_bytes.push_back("\\");
    str_bytes.push_back(letter);
    // now and then no digits at all
    if ($urandom_range(0, 7) != 0) add_hex(cp, $urandom_range(hex_width(cp), max_nd));
  endfunction

  function automatic void build_string();
    string       simple_esc;
    int          ntok;
    logic [7:0]  c;
    logic [31:0] cp;
    simple_esc = "abeEfnrtv\\'";
    str_bytes.delete();
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: begin
          c = 8'($urandom_range(0, 255));
          str_bytes.push_back(c);
          if (c == "\\") str_bytes.push_back(c);
        end
        6, 7, 8: begin
          str_bytes.push_back("\\");
          str_bytes.push_back(simple_esc[$urandom_range(0, simple_esc.len() - 1)]);
        end
        9, 10: add_hex_escape("x", $urandom_range(0, 255), 2);
        11, 12: add_hex_escape("u", $urandom_range(0, 16'hFFFF), 4);
        13, 14: begin
          cp = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'h10FFFF) : $urandom;
          add_hex_escape("U", cp, 8);
        end
        15, 16: begin
          str_bytes.push_back("\\");
          repeat ($urandom_range(1, 3)) str_bytes.push_back("0" + 8'($urandom_range(0, 7)));
        end
        17: begin
          str_bytes.push_back("\\");
          str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        18: str_bytes.push_back(8'($urandom_range(0, 255)));
        default: str_bytes.push_back("\\");
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- receiver

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    $display("mismatch at output beat %0d: %s got 0x%0h, want 0x%0h", out_cnt, what, got,
             want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("beat with nothing pending, data", m_axis_tdata, 0);
      end else begin
        head = decoded_q.pop_front();
        if (m_axis_tdata !== head.data) report_mismatch("out_byte", m_axis_tdata, head.data);
        if (m_axis_tuser[0] !== head.valid)
          report_mismatch("byte_valid", m_axis_tuser[0], head.valid);
        if (m_axis_tuser[1] !== head.err)
          report_mismatch("error_flag", m_axis_tuser[1], head.err);
        if (m_axis_tuser[3:2] !== head.kind)
          report_mismatch("error_kind", m_axis_tuser[3:2], head.kind);
        if (m_axis_tuser[4] !== head.run_last)
          report_mismatch("run_last", m_axis_tuser[4], head.run_last);
        if (m_axis_tuser[7:5] !== 3'b000) report_mismatch("tuser pad", m_axis_tuser[7:5], 0);
        if (m_axis_tlast !== head.done) report_mismatch("text_done", m_axis_tlast, head.done);
      end
      out_cnt++;
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    int unsigned rand_items;
    logic        hold_used;
    logic        pause_used;
    rand_items = 0;
    hold_used = 1'b0;
    pause_used = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    to_plain();

    // plain extremes, error codes, close-out, 4-byte utf-8 plus ending byte,
    // range overflow cut by end of text, octal maximum, quote escape
    dir_tab.push_back(step_fixed(8'h00, 1'b0, 8'h00, 1'b1, 1'b0, '0));
    dir_tab.push_back(step_fixed(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0, '0));
    dir_tab.push_back(step_fixed("\\", 1'b1, 8'h00, 1'b0, 1'b1, ERR_TRAILING));
    dir_tab.push_back(step_only("\\", 1'b0));
    dir_tab.push_back(step_only("x", 1'b0));
    dir_tab.push_back(step_fixed("g", 1'b0, 8'h00, 1'b0, 1'b1, ERR_NEED_DIGITS));
    dir_tab.push_back(step_fixed("A", 1'b1, 8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(step_only("\\", 1'b0));
    dir_tab.push_back(step_only("U", 1'b0));
    dir_tab.push_back(step_only("1", 1'b0));
    dir_tab.push_back(step_only("0", 1'b0));
    dir_tab.push_back(step_only("F", 1'b0));
    dir_tab.push_back(step_only("f", 1'b0));
    dir_tab.push_back(step_only("F", 1'b0));
    dir_tab.push_back(step_only("f", 1'b0));
    dir_tab.push_back(step_only("Z", 1'b1));
    dir_tab.push_back(step_only("\\", 1'b0));
    dir_tab.push_back(step_only("U", 1'b0));
    dir_tab.push_back(step_only("1", 1'b0));
    dir_tab.push_back(step_only("1", 1'b0));
    dir_tab.push_back(step_only("0", 1'b0));
    dir_tab.push_back(step_only("0", 1'b0));
    dir_tab.push_back(step_only("0", 1'b0));
    dir_tab.push_back(step_fixed("0", 1'b1, 8'h00, 1'b0, 1'b1, ERR_RANGE));
    dir_tab.push_back(step_only("\\", 1'b0));
    dir_tab.push_back(step_only("7", 1'b0));
    dir_tab.push_back(step_only("7", 1'b0));
    dir_tab.push_back(step_only("7", 1'b0));
    dir_tab.push_back(step_only("\\", 1'b0));
    dir_tab.push_back(step_fixed("'", 1'b1, "'", 1'b1, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      maybe_idle();
      send_beat(dir_tab[i].in_byte, dir_tab[i].last, dir_tab[i].fixed, dir_tab[i].want);
    end

    while (rand_items < RAND_ITEMS) begin
      build_string();
      foreach (str_bytes[i]) begin
        maybe_idle();
        // bytes dropped after an error only get ignored
        if (st_mode != MODE_DROP) rand_items++;
        send_beat(str_bytes[i], i == str_bytes.size() - 1, 1'b0, '0);
        if (!hold_used && rand_items >= 150) begin
          long_hold = 1'b1;
          hold_used = 1'b1;
        end
      end
      if (!pause_used && rand_items >= 300) begin
        drain_out();
        pause_used = 1'b1;
      end
      if (rand_items >= 390) quiet = 1'b1;
    end

    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("** ansi_c_escape_decoder: PASSED **");
    end else begin
      $display("** ansi_c_escape_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// File: ansi_c_escape_decoder.f
src/aced_pkg.sv
src/aced_decode.sv
src/ansi_c_escape_decoder.sv
tb/sv/tb_top.sv
